// ===== design/ssr_pkg.sv =====
// ---------------------------------------------------------------------------
// ssr_pkg: shared types and constants for the streaming find-and-replace
// Payload structs, register indexes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

   localparam int MAX_PATTERN_BYTES     = 8;
   localparam int MAX_REPLACEMENT_BYTES = 8;
   localparam int BYTE_W                = 8;
   localparam int CSR_DATA_W            = 64;
   localparam int CSR_INDEX_W           = 2;
   localparam int LEN_W                 = 4;
   localparam int CNT_W                 = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int HOLD_IDX_W            = $clog2(MAX_PATTERN_BYTES);
   localparam int REP_IDX_W             = $clog2(MAX_REPLACEMENT_BYTES);

   localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              stream_last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              run_end;
      logic              stream_end;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_REPLACE,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_HEAD,
      EMIT_REP,
      EMIT_NEWLINE
   } emit_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic         load;
      logic         start_rep;
      emit_sel_type emit_sel;
      logic         emit_final;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_newline;
      logic item_last;
      logic item_newline;
      logic cnt_zero;
      logic cnt_one;
      logic full_match;
      logic head_prefix;
      logic tail_prefix;
      logic rep_final;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/ssr_datapath.sv =====
// ---------------------------------------------------------------------------
// ssr_datapath: hold buffer, pattern compare and output register
// Keeps the configuration registers, the bytes held as a partial match, the
// replacement index and the registered result, and reports match status.
// ---------------------------------------------------------------------------
`default_nettype none

module ssr_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [ssr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ssr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire ssr_pkg::req_type                  req_payload,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid,
   output ssr_pkg::rsp_type                       rsp_payload,
   input  wire ssr_pkg::ctrl_cmd_type             cmd,
   output ssr_pkg::dp_status_type                 status
);
   import ssr_pkg::*;

   logic [CSR_DATA_W-1:0] pat_ff, pat_in;
   logic [LEN_W-1:0]      plen_ff, plen_in;
   logic [CSR_DATA_W-1:0] rep_ff, rep_in;
   logic [LEN_W-1:0]      rlen_ff, rlen_in;

   logic [BYTE_W-1:0]     hold_ff [MAX_PATTERN_BYTES];
   logic [BYTE_W-1:0]     hold_in [MAX_PATTERN_BYTES];
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [REP_IDX_W-1:0]  rep_idx_ff, rep_idx_in;
   logic                  last_ff, last_in;
   logic                  nl_ff, nl_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   logic [CNT_W-1:0]      plen_eff;
   logic [REP_IDX_W-1:0]  rep_last_idx;
   logic                  head_ok;
   logic                  tail_ok;
   logic                  req_nl;
   logic                  shift;
   logic [BYTE_W-1:0]     emit_byte;

   // Clamp a length register to 1..MAX
   function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] v,
                                               input int max);
      logic [CNT_W-1:0] r;
      if (v == '0) begin
         r = CNT_W'(1);
      end else if (CNT_W'(v) > CNT_W'(max)) begin
         r = CNT_W'(max);
      end else begin
         r = CNT_W'(v);
      end
      return r;
   endfunction

   assign plen_eff     = eff_len(plen_ff, MAX_PATTERN_BYTES);
   assign rep_last_idx = REP_IDX_W'(eff_len(rlen_ff, MAX_REPLACEMENT_BYTES) - CNT_W'(1));
   assign req_nl       = (req_payload.in_byte == NEWLINE_BYTE);
   assign shift        = (cmd.emit_sel == EMIT_HEAD);

   // Compare held bytes against the pattern, from the head and one byte on
   always_comb begin
      head_ok = 1'b1;
      tail_ok = 1'b1;
      for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
         if (CNT_W'(i) < cnt_ff && hold_ff[i] != pat_ff[i*BYTE_W +: BYTE_W]) begin
            head_ok = 1'b0;
         end
      end
      for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
         if (CNT_W'(i + 1) < cnt_ff && hold_ff[i+1] != pat_ff[i*BYTE_W +: BYTE_W]) begin
            tail_ok = 1'b0;
         end
      end
   end

   // Select the byte to transfer
   always_comb begin
      case (cmd.emit_sel)
         EMIT_HEAD:    emit_byte = hold_ff[0];
         EMIT_REP:     emit_byte = rep_ff[rep_idx_ff*BYTE_W +: BYTE_W];
         EMIT_NEWLINE: emit_byte = NEWLINE_BYTE;
         default:      emit_byte = '0;
      endcase
   end

   // Configuration registers
   always_comb begin
      pat_in  = pat_ff;
      plen_in = plen_ff;
      rep_in  = rep_ff;
      rlen_in = rlen_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PATTERN_BYTES:      pat_in  = csr_wdata;
            CSR_PATTERN_LENGTH:     plen_in = csr_wdata[LEN_W-1:0];
            CSR_REPLACEMENT_BYTES:  rep_in  = csr_wdata;
            CSR_REPLACEMENT_LENGTH: rlen_in = csr_wdata[LEN_W-1:0];
         endcase
      end
   end

   // Hold buffer, count and item flags
   always_comb begin
      hold_in    = hold_ff;
      cnt_in     = cnt_ff;
      rep_idx_in = rep_idx_ff;
      last_in    = last_ff;
      nl_in      = nl_ff;
      if (csr_we) begin
         cnt_in = '0;
      end else if (cmd.load) begin
         last_in = req_payload.stream_last;
         nl_in   = req_nl;
         if (!req_nl) begin
            hold_in[cnt_ff[HOLD_IDX_W-1:0]] = req_payload.in_byte;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else if (cmd.start_rep) begin
         cnt_in     = '0;
         rep_idx_in = '0;
      end else if (shift) begin
         for (int i = 0; i < MAX_PATTERN_BYTES - 1; i++) begin
            hold_in[i] = hold_ff[i+1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end else if (cmd.emit_sel == EMIT_REP) begin
         rep_idx_in = rep_idx_ff + REP_IDX_W'(1);
      end
   end

   // Output register: load on transfer out of the core, drop when taken
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit_sel != EMIT_NONE) begin
         rsp_in.out_byte   = emit_byte;
         rsp_in.run_end    = cmd.emit_final;
         rsp_in.stream_end = cmd.emit_final & last_ff;
         rsp_valid_in      = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff       <= '0;
         plen_ff      <= LEN_W'(1);
         rep_ff       <= '0;
         rlen_ff      <= LEN_W'(1);
         cnt_ff       <= '0;
         rep_idx_ff   <= '0;
         last_ff      <= 1'b0;
         nl_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pat_ff       <= pat_in;
         plen_ff      <= plen_in;
         rep_ff       <= rep_in;
         rlen_ff      <= rlen_in;
         cnt_ff       <= cnt_in;
         rep_idx_ff   <= rep_idx_in;
         last_ff      <= last_in;
         nl_ff        <= nl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Status towards the controller
   always_comb begin
      status.req_newline  = req_nl;
      status.item_last    = last_ff;
      status.item_newline = nl_ff;
      status.cnt_zero     = (cnt_ff == '0);
      status.cnt_one      = (cnt_ff == CNT_W'(1));
      status.full_match   = (cnt_ff == plen_eff) && head_ok;
      status.head_prefix  = (cnt_ff < plen_eff) && head_ok;
      status.tail_prefix  = tail_ok;
      status.rep_final    = (rep_idx_ff == rep_last_idx);
      status.out_free     = !rsp_valid_ff || rsp_ready;
   end

endmodule

`default_nettype wire

// ===== design/ssr_ctrl.sv =====
// ---------------------------------------------------------------------------
// ssr_ctrl: sequencing state machine
// Accepts one item, then walks the held bytes: replace a full match, release
// the oldest byte on a mismatch, and flush on newline or end of stream.
// ---------------------------------------------------------------------------
`default_nettype none

module ssr_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ssr_pkg::dp_status_type status,
   output ssr_pkg::ctrl_cmd_type       cmd
);
   import ssr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cmd.load       = 1'b0;
      cmd.start_rep  = 1'b0;
      cmd.emit_sel   = EMIT_NONE;
      cmd.emit_final = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_newline ? ST_DRAIN : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.full_match) begin
               cmd.start_rep = 1'b1;
               state_in      = ST_REPLACE;
            end else if (status.head_prefix) begin
               // still a partial match: hold it, or flush at end of stream
               state_in = status.item_last ? ST_DRAIN : ST_IDLE;
            end else if (status.out_free) begin
               // release the oldest byte; last one if nothing else follows
               cmd.emit_sel   = EMIT_HEAD;
               cmd.emit_final = status.cnt_one ||
                                (status.tail_prefix && !status.item_last);
               if (status.cnt_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REPLACE: begin
            if (status.out_free) begin
               cmd.emit_sel   = EMIT_REP;
               cmd.emit_final = status.rep_final;
               if (status.rep_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               if (status.cnt_zero) begin
                  cmd.emit_sel   = EMIT_NEWLINE;
                  cmd.emit_final = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.emit_sel   = EMIT_HEAD;
                  cmd.emit_final = status.cnt_one && !status.item_newline;
                  if (status.cnt_one && !status.item_newline) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/stream_substring_replace.sv =====
// ---------------------------------------------------------------------------
// stream_substring_replace: streaming find-and-replace on a byte stream
// Replaces every leftmost, non-overlapping occurrence of the configured
// pattern by the replacement text; newline and end of stream flush.
// ---------------------------------------------------------------------------
//
//   Port group   Direction  Handshake          Carries
//   req_*        in         valid / ready      one text byte and end mark
//   rsp_*        out        valid / ready      one rewritten byte and marks
//   csr_*        in         write enable only  pattern and replacement setup
//
// An item is accepted in ST_IDLE, then its result bytes leave one at a time
// through the single-byte output register of the datapath; a full match first
// resets the replacement index, and held bytes that stay held return to ST_IDLE.
// Reset is synchronous and clears the held count, the lengths to one and the
// pattern and replacement to zero. A stalled rsp_ready stalls every output;
// the next item is taken once each byte of the previous one is sent or held.
// ---------------------------------------------------------------------------
`default_nettype none

module stream_substring_replace (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire ssr_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output ssr_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_we,
   input  wire logic [ssr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ssr_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import ssr_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   ssr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ssr_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_payload (req_payload),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

`default_nettype wire

// ===== design/ssr_checker.sv =====
// ---------------------------------------------------------------------------
// ssr_checker: port-level checks for the find-and-replace block
// Watches the top-level ports only and reports violations by error.
// ---------------------------------------------------------------------------
`default_nettype none

module ssr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ssr_pkg::rsp_type rsp_payload
);
   import ssr_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // End of stream only on the last byte of a run
   a_end_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.stream_end || rsp_payload.run_end))
      else $error("stream_end without run_end");

   // One item at a time: no accept in the cycle after an accept
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while previous item in progress");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
